// File: hw/rtl/mtcp_pkg.sv
// Shared types and constants for the money text to cents parser.
// No dependencies; every other file in this block imports it.
package mtcp_pkg;

   // Result status codes; ST_OK also marks "no syntax error latched".
   typedef enum logic [2:0] {
      ST_OK                = 3'd0,
      ST_BAD_CHAR          = 3'd1,
      ST_BAD_SIGN          = 3'd2,
      ST_SECOND_POINT      = 3'd3,
      ST_TOO_MANY_DECIMALS = 3'd4,
      ST_NO_DIGITS         = 3'd5,
      ST_OVERFLOW          = 3'd6
   } status_type;

   // Request kind carried on tuser.
   localparam logic MODE_CHAR = 1'b0;
   localparam logic MODE_END  = 1'b1;

   // Characters of interest.
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_POINT  = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   // One registered request.
   typedef struct packed {
      logic       mode;
      logic [7:0] character;
   } req_item_type;

endpackage

// File: hw/rtl/mtcp_char_parser.sv
// Per-character parse state and the end-of-text snapshot register.
// Depends on mtcp_pkg.
module mtcp_char_parser #(
   parameter int  FRACTION_DIGITS = 2,
   parameter int  AMOUNT_BITS     = 64,
   localparam int SCALE_W         = $clog2(10**FRACTION_DIGITS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  mtcp_pkg::req_item_type   in_item,
   output logic                     in_pop,
   output logic                     snap_valid,
   input  logic                     snap_ready,
   output mtcp_pkg::status_type     snap_status,
   output logic [AMOUNT_BITS-1:0]   snap_value,
   output logic [SCALE_W-1:0]       snap_scale
);
   import mtcp_pkg::*;

   localparam int MAG_W = AMOUNT_BITS - 1;
   localparam int ACC_W = MAG_W + 4;
   localparam int FC_W  = $clog2(FRACTION_DIGITS + 2);

   localparam logic [63:0] MAX_MAG = (64'd1 << (AMOUNT_BITS - 1)) - 64'd1;
   localparam logic [63:0] LIM0    = MAX_MAG;
   localparam logic [63:0] LIM1    = MAX_MAG / 64'd10;
   localparam logic [63:0] LIM2    = MAX_MAG / 64'd100;
   localparam logic [63:0] LIM3    = MAX_MAG / 64'd1000;
   localparam logic [63:0] LIM4    = MAX_MAG / 64'd10000;

   logic             sign_ff, sign_in;
   logic             neg_ff, neg_in;
   logic             digit_ff, digit_in;
   logic             point_ff, point_in;
   logic [FC_W-1:0]  frac_ff, frac_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic             ovf_ff, ovf_in;
   status_type       syn_ff, syn_in;

   logic                   snap_valid_ff, snap_valid_in;
   status_type             snap_status_ff;
   logic [AMOUNT_BITS-1:0] snap_value_ff;
   logic [SCALE_W-1:0]     snap_scale_ff;

   logic                   end_pop;
   logic [ACC_W-1:0]       acc;
   logic [2:0]             pad_count;
   logic                   pad_over;
   logic [SCALE_W-1:0]     end_scale;
   status_type             end_status;
   logic [AMOUNT_BITS-1:0] mag_val;
   logic [AMOUNT_BITS-1:0] end_value;

   assign in_pop  = in_valid && (in_item.mode == MODE_CHAR || !snap_valid_ff || snap_ready);
   assign end_pop = in_pop && (in_item.mode == MODE_END);

   // magnitude * 10 + digit; any set bit from MAG_W upward means past the limit
   assign acc = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1)
              + ACC_W'(in_item.character[3:0]);

   always_comb begin
      sign_in  = sign_ff;
      neg_in   = neg_ff;
      digit_in = digit_ff;
      point_in = point_ff;
      frac_in  = frac_ff;
      mag_in   = mag_ff;
      ovf_in   = ovf_ff;
      syn_in   = syn_ff;
      if (end_pop) begin
         sign_in  = 1'b0;
         neg_in   = 1'b0;
         digit_in = 1'b0;
         point_in = 1'b0;
         frac_in  = '0;
         mag_in   = '0;
         ovf_in   = 1'b0;
         syn_in   = ST_OK;
      end else if (in_pop && syn_ff == ST_OK) begin
         case (in_item.character) inside
            CH_SPACE, CH_TAB, CH_COMMA, CH_DOLLAR: begin
            end
            CH_PLUS, CH_MINUS: begin
               if (sign_ff || digit_ff || point_ff) begin
                  syn_in = ST_BAD_SIGN;
               end else begin
                  sign_in = 1'b1;
                  neg_in  = (in_item.character == CH_MINUS);
               end
            end
            CH_POINT: begin
               if (point_ff) begin
                  syn_in = ST_SECOND_POINT;
               end else begin
                  point_in = 1'b1;
               end
            end
            [CH_ZERO:CH_NINE]: begin
               digit_in = 1'b1;
               if (point_ff && frac_ff >= FC_W'(FRACTION_DIGITS)) begin
                  syn_in = ST_TOO_MANY_DECIMALS;
               end else begin
                  if (point_ff) begin
                     frac_in = frac_ff + FC_W'(1);
                  end
                  if (!ovf_ff) begin
                     if (acc[ACC_W-1:MAG_W] != '0) begin
                        ovf_in = 1'b1;
                     end else begin
                        mag_in = acc[MAG_W-1:0];
                     end
                  end
               end
            end
            default: begin
               syn_in = ST_BAD_CHAR;
            end
         endcase
      end
   end

   // End of text: pad missing fraction digits by checking against limit / 10^k.
   assign pad_count = 3'(FRACTION_DIGITS) - 3'(frac_ff);
   assign mag_val   = {1'b0, mag_ff};

   always_comb begin
      case (pad_count)
         3'd0: begin
            pad_over  = 64'(mag_ff) > LIM0;
            end_scale = SCALE_W'(64'd1);
         end
         3'd1: begin
            pad_over  = 64'(mag_ff) > LIM1;
            end_scale = SCALE_W'(64'd10);
         end
         3'd2: begin
            pad_over  = 64'(mag_ff) > LIM2;
            end_scale = SCALE_W'(64'd100);
         end
         3'd3: begin
            pad_over  = 64'(mag_ff) > LIM3;
            end_scale = SCALE_W'(64'd1000);
         end
         3'd4: begin
            pad_over  = 64'(mag_ff) > LIM4;
            end_scale = SCALE_W'(64'd10000);
         end
         default: begin
            pad_over  = 1'b0;
            end_scale = SCALE_W'(64'd1);
         end
      endcase
   end

   always_comb begin
      if (syn_ff != ST_OK) begin
         end_status = syn_ff;
      end else if (!digit_ff) begin
         end_status = ST_NO_DIGITS;
      end else if (ovf_ff || pad_over) begin
         end_status = ST_OVERFLOW;
      end else begin
         end_status = ST_OK;
      end
      if (end_status != ST_OK) begin
         end_value = '0;
      end else if (neg_ff) begin
         end_value = ~mag_val + AMOUNT_BITS'(1);
      end else begin
         end_value = mag_val;
      end
   end

   always_comb begin
      if (end_pop) begin
         snap_valid_in = 1'b1;
      end else if (snap_ready) begin
         snap_valid_in = 1'b0;
      end else begin
         snap_valid_in = snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_ff       <= 1'b0;
         neg_ff        <= 1'b0;
         digit_ff      <= 1'b0;
         point_ff      <= 1'b0;
         frac_ff       <= '0;
         mag_ff        <= '0;
         ovf_ff        <= 1'b0;
         syn_ff        <= ST_OK;
         snap_valid_ff <= 1'b0;
      end else begin
         sign_ff       <= sign_in;
         neg_ff        <= neg_in;
         digit_ff      <= digit_in;
         point_ff      <= point_in;
         frac_ff       <= frac_in;
         mag_ff        <= mag_in;
         ovf_ff        <= ovf_in;
         syn_ff        <= syn_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_pop) begin
         snap_status_ff <= end_status;
         snap_value_ff  <= end_value;
         snap_scale_ff  <= end_scale;
      end
   end

   assign snap_valid  = snap_valid_ff;
   assign snap_status = snap_status_ff;
   assign snap_value  = snap_value_ff;
   assign snap_scale  = snap_scale_ff;

   a_end_clears_state: assert property (@(posedge clock) disable iff (reset)
      end_pop |=> (mag_ff == '0 && !digit_ff && !point_ff && !sign_ff && syn_ff == ST_OK))
      else $error("parse state not cleared after end of text");

   a_error_latched: assert property (@(posedge clock) disable iff (reset)
      (syn_ff != ST_OK && !end_pop) |=> $stable(syn_ff))
      else $error("latched syntax error changed before end of text");

endmodule

// File: hw/rtl/mtcp_scaler.sv
// Fraction padding multiply (split into two partial products) and result register.
// Depends on mtcp_pkg.
module mtcp_scaler #(
   parameter int  FRACTION_DIGITS = 2,
   parameter int  AMOUNT_BITS     = 64,
   localparam int SCALE_W         = $clog2(10**FRACTION_DIGITS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     snap_valid,
   output logic                     snap_ready,
   input  mtcp_pkg::status_type     snap_status,
   input  logic [AMOUNT_BITS-1:0]   snap_value,
   input  logic [SCALE_W-1:0]       snap_scale,
   output logic                     out_valid,
   input  logic                     out_ready,
   output mtcp_pkg::status_type     out_status,
   output logic [AMOUNT_BITS-1:0]   out_amount
);
   import mtcp_pkg::*;

   localparam int LO_W  = AMOUNT_BITS / 2;
   localparam int HI_W  = AMOUNT_BITS - LO_W;
   localparam int SUM_W = AMOUNT_BITS + SCALE_W;

   logic                     pp_valid_ff, pp_valid_in;
   status_type               pp_status_ff;
   logic [LO_W+SCALE_W-1:0]  pp_lo_ff, pp_lo_in;
   logic [HI_W-1:0]          pp_hi_ff;
   logic [HI_W+SCALE_W-1:0]  pp_hi_full;
   logic                     pp_ready;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff;
   logic [AMOUNT_BITS-1:0]   rsp_amount_ff, rsp_amount_in;
   logic [SUM_W-1:0]         sum_w;

   assign pp_ready   = !rsp_valid_ff || out_ready;
   assign snap_ready = !pp_valid_ff || pp_ready;

   // Only the low HI_W bits of the upper product land in the result.
   assign pp_lo_in   = (LO_W+SCALE_W)'(snap_value[LO_W-1:0]) * (LO_W+SCALE_W)'(snap_scale);
   assign pp_hi_full = (HI_W+SCALE_W)'(snap_value[AMOUNT_BITS-1:LO_W])
                     * (HI_W+SCALE_W)'(snap_scale);

   assign sum_w = SUM_W'({pp_hi_ff, {LO_W{1'b0}}}) + SUM_W'(pp_lo_ff);
   assign rsp_amount_in = sum_w[AMOUNT_BITS-1:0];

   always_comb begin
      if (snap_valid && snap_ready) begin
         pp_valid_in = 1'b1;
      end else if (pp_ready) begin
         pp_valid_in = 1'b0;
      end else begin
         pp_valid_in = pp_valid_ff;
      end
      if (pp_valid_ff && pp_ready) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pp_valid_ff  <= pp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_valid && snap_ready) begin
         pp_status_ff <= snap_status;
         pp_lo_ff     <= pp_lo_in;
         pp_hi_ff     <= pp_hi_full[HI_W-1:0];
      end
      if (pp_valid_ff && pp_ready) begin
         rsp_status_ff <= pp_status_ff;
         rsp_amount_ff <= rsp_amount_in;
      end
   end

   assign out_valid  = rsp_valid_ff;
   assign out_status = rsp_status_ff;
   assign out_amount = rsp_amount_ff;

   a_error_zero_amount: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> rsp_amount_ff == '0)
      else $error("nonzero amount with error status");

   a_amount_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_amount_ff != {1'b1, {(AMOUNT_BITS-1){1'b0}}})
      else $error("amount outside symmetric range");

endmodule

// File: hw/rtl/money_text_to_cents_parser.sv
// Money text to cents parser: one character per request, signed cents on end of text.
// End of text passes the input, snapshot, partial-product and result registers.
// Throughput: one request per cycle; end of text can stall under result back-pressure.
// Reset: synchronous, active high; clears parse state and all pipeline valids.
// Depends on mtcp_pkg, mtcp_char_parser and mtcp_scaler.
module money_text_to_cents_parser #(
   parameter int  FRACTION_DIGITS = 2,
   parameter int  AMOUNT_BITS     = 64,
   localparam int RSP_W           = ((3 + AMOUNT_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] character
   input  logic             req_tuser,   // [0] mode (0 character, 1 end of text)
   // result channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // [2:0] status, [AMOUNT_BITS+2:3] amount, zero pad
);
   import mtcp_pkg::*;

   localparam int SCALE_W = $clog2(10**FRACTION_DIGITS + 1);

   // Input register: holds one request until the parser consumes it.
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         in_pop;

   // Snapshot handoff: status, signed value and padding scale for one amount.
   logic                   snap_valid, snap_ready;
   status_type             snap_status;
   logic [AMOUNT_BITS-1:0] snap_value;
   logic [SCALE_W-1:0]     snap_scale;

   status_type             out_status;
   logic [AMOUNT_BITS-1:0] out_amount;

   // Accept whenever the input register is empty or drains this cycle.
   assign req_tready = !in_valid_ff || in_pop;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (in_pop) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture payload on accept; no reset needed.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.mode      <= req_tuser;
         in_item_ff.character <= req_tdata;
      end
   end

   // Update sign/point/digit state per character; snapshot on end of text.
   mtcp_char_parser #(
      .FRACTION_DIGITS (FRACTION_DIGITS),
      .AMOUNT_BITS     (AMOUNT_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_valid_ff),
      .in_item     (in_item_ff),
      .in_pop      (in_pop),
      .snap_valid  (snap_valid),
      .snap_ready  (snap_ready),
      .snap_status (snap_status),
      .snap_value  (snap_value),
      .snap_scale  (snap_scale)
   );

   // Multiply by 10^(missing fraction digits) and hold the result.
   mtcp_scaler #(
      .FRACTION_DIGITS (FRACTION_DIGITS),
      .AMOUNT_BITS     (AMOUNT_BITS)
   ) u_scaler (
      .clock       (clock),
      .reset       (reset),
      .snap_valid  (snap_valid),
      .snap_ready  (snap_ready),
      .snap_status (snap_status),
      .snap_value  (snap_value),
      .snap_scale  (snap_scale),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_status  (out_status),
      .out_amount  (out_amount)
   );

   // Pack status low, amount above it, zero fill to whole bytes.
   assign rsp_tdata = RSP_W'({out_amount, out_status});

   a_pop_needs_valid: assert property (@(posedge clock) disable iff (reset)
      in_pop |-> in_valid_ff)
      else $error("request consumed from empty input register");

endmodule
